FILE: rtl/stp_pkg.sv
// Shared types, constants and codes of the step/direction generator.
package stp_pkg;

  localparam int POS_W      = 32;
  localparam int DIGIT_W    = 4;
  localparam int N_DIGITS   = POS_W / DIGIT_W;
  localparam int DCNT_W     = $clog2(N_DIGITS);
  localparam int SPEED_W    = 20;
  localparam int DIV_CNT_W  = $clog2(SPEED_W);
  localparam int CFG_IDX_W  = 1;

  localparam logic [SPEED_W-1:0] MICROS_PER_SEC    = 20'd1000000;
  localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RST = 20'd1000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_ACTIVE_LOW = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  typedef enum logic [1:0] {
    MODE_MOVE   = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_SETPOS = 2'd3
  } stp_mode_t;

  typedef enum logic {
    PASS_TICK = 1'b0,
    PASS_MOVE = 1'b1
  } stp_pass_t;

  // control from the sequencer to the serial datapath
  typedef struct packed {
    logic      start;
    stp_pass_t kind;
    logic      load_pos;
    logic      load_tgt;
    logic      commit;
    logic      dir_neg;
  } stp_ctl_t;

  // flags from the serial datapath, valid in the last digit cycle
  typedef struct packed {
    logic last;
    logic eq_old;
    logic eq_new;
    logic ge;
    logic tgt_gt;
  } stp_flags_t;

endpackage

FILE: rtl/stp_div.sv
// Bit-serial restoring divider: 1000000 / divisor, one quotient bit a cycle.
module stp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [stp_pkg::SPEED_W-1:0] divisor,
  output logic                        valid,
  output logic [stp_pkg::SPEED_W-1:0] quotient
);

  localparam int W = stp_pkg::SPEED_W;

  logic [W-1:0]                  d_r;
  logic [W-1:0]                  rem_r;
  logic [W-1:0]                  q_r;
  logic [stp_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          valid_r;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         take;

  assign trial = {rem_r, stp_pkg::MICROS_PER_SEC[cnt_r]};
  assign diff  = trial - {1'b0, d_r};
  assign take  = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (start) begin
      d_r     <= divisor;
      rem_r   <= '0;
      cnt_r   <= stp_pkg::DIV_CNT_W'(W - 1);
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= take ? diff[W-1:0] : trial[W-1:0];
      q_r   <= {q_r[W-2:0], take};
      if (cnt_r == '0) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign valid    = valid_r;
  assign quotient = q_r;

endmodule

FILE: rtl/stp_serial.sv
// Nibble-serial axis datapath: position, target and step time, compared and stepped a digit a cycle.
module stp_serial (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stp_pkg::stp_ctl_t             ctl,
  input  logic [stp_pkg::POS_W-1:0]     load_val,
  input  logic [stp_pkg::POS_W-1:0]     now_val,
  input  logic [stp_pkg::SPEED_W-1:0]   ivl_val,
  output stp_pkg::stp_flags_t           flags,
  output logic [stp_pkg::POS_W-1:0]     position,
  output logic [stp_pkg::POS_W-1:0]     target
);

  localparam int PW = stp_pkg::POS_W;
  localparam int DW = stp_pkg::DIGIT_W;

  logic [PW-1:0] pos_r, tgt_r, last_r, now_r, ivl_r, pnew_r;
  logic [stp_pkg::DCNT_W-1:0] cnt_r;
  logic          busy_r;
  stp_pkg::stp_pass_t kind_r;
  logic          c_r, b1_r, b2_r, bm_r, eq_old_r, eq_new_r;

  logic [DW-1:0] p, t, n, l, iv, addend, pm, tm;
  logic [DW:0]   add, sub1, sub2, subm;
  logic          last;

  assign p  = pos_r[DW-1:0];
  assign t  = tgt_r[DW-1:0];
  assign n  = now_r[DW-1:0];
  assign l  = last_r[DW-1:0];
  assign iv = ivl_r[DW-1:0];
  assign last = busy_r && (cnt_r == stp_pkg::DCNT_W'(stp_pkg::N_DIGITS - 1));

  // step by one: add zero with carry in, or all ones for minus one
  assign addend = ctl.dir_neg ? {DW{1'b1}} : {DW{1'b0}};
  assign add  = {1'b0, p} + {1'b0, addend} + {{DW{1'b0}}, c_r};
  assign sub1 = {1'b0, n} - {1'b0, l} - {{DW{1'b0}}, b1_r};
  assign sub2 = {1'b0, sub1[DW-1:0]} - {1'b0, iv} - {{DW{1'b0}}, b2_r};

  // signed compare: flip the sign bits in the top digit, then unsigned borrow
  always_comb begin
    pm = p;
    tm = t;
    if (last) begin
      pm[DW-1] = ~p[DW-1];
      tm[DW-1] = ~t[DW-1];
    end
  end
  assign subm = {1'b0, pm} - {1'b0, tm} - {{DW{1'b0}}, bm_r};

  assign flags.last   = last;
  assign flags.eq_old = eq_old_r & (p == t);
  assign flags.eq_new = eq_new_r & (add[DW-1:0] == t);
  assign flags.ge     = ~sub2[DW];
  assign flags.tgt_gt = subm[DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tgt_r  <= '0;
      last_r <= '0;
      busy_r <= 1'b0;
      cnt_r  <= '0;
      kind_r <= stp_pkg::PASS_TICK;
    end else if (ctl.start) begin
      now_r    <= now_val;
      ivl_r    <= {{(PW - stp_pkg::SPEED_W){1'b0}}, ivl_val};
      kind_r   <= ctl.kind;
      cnt_r    <= '0;
      busy_r   <= 1'b1;
      c_r      <= ~ctl.dir_neg;
      b1_r     <= 1'b0;
      b2_r     <= 1'b0;
      bm_r     <= 1'b0;
      eq_old_r <= 1'b1;
      eq_new_r <= 1'b1;
    end else if (busy_r) begin
      pos_r    <= {p, pos_r[PW-1:DW]};
      tgt_r    <= {t, tgt_r[PW-1:DW]};
      last_r   <= {l, last_r[PW-1:DW]};
      now_r    <= {n, now_r[PW-1:DW]};
      ivl_r    <= {iv, ivl_r[PW-1:DW]};
      pnew_r   <= {add[DW-1:0], pnew_r[PW-1:DW]};
      c_r      <= add[DW];
      b1_r     <= sub1[DW];
      b2_r     <= sub2[DW];
      bm_r     <= subm[DW];
      eq_old_r <= flags.eq_old;
      eq_new_r <= flags.eq_new;
      cnt_r    <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
        if (ctl.commit && kind_r == stp_pkg::PASS_TICK) begin
          pos_r  <= {add[DW-1:0], pnew_r[PW-1:DW]};
          last_r <= {n, now_r[PW-1:DW]};
        end
      end
    end else begin
      if (ctl.load_pos) pos_r <= load_val;
      if (ctl.load_tgt) tgt_r <= load_val;
    end
  end

  assign position = pos_r;
  assign target   = tgt_r;

endmodule

FILE: rtl/stepper_step_dir_generator_core.sv
// Top level of the constant-rate step/direction generator for one stepper axis.
//
// Input channel (in_valid/in_ready) takes one command item: move, time tick,
// stop or set position. Every item yields exactly one result item on the
// output channel (out_valid/out_ready) showing the axis state after it.
// Configuration (cfg_we/cfg_index/cfg_wdata) sets the default speed and the
// enable pin polarity; writes take effect at once, no read-back.
//
// Items are handled one at a time. Stop and set position go straight to the
// result register; a tick first runs the nibble-serial position / time
// compare, a move runs the serial position compare alongside the bit-serial
// divider for 1000000 / speed (one quotient bit a cycle) and waits for the quotient.
// in_ready is high whenever the sequencer is idle, also while a result still
// waits in the output register; if the receiver stalls, the next result waits
// in its final state until the output register is free.
// Reset (synchronous, rst_n low) clears position, target, direction, motion
// and enable, arms the first-step flag and loads the register defaults.
module stepper_step_dir_generator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stp_pkg::SPEED_W-1:0]          cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic signed [stp_pkg::POS_W-1:0]     in_target_steps,
  input  logic [stp_pkg::SPEED_W-1:0]          in_speed_steps_per_sec,
  input  logic [stp_pkg::POS_W-1:0]            in_now_micros,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_step_pulse,
  output logic                                 out_dir_level,
  output logic                                 out_enable_level,
  output logic signed [stp_pkg::POS_W-1:0]     out_position_steps,
  output logic signed [stp_pkg::POS_W-1:0]     out_target_position,
  output logic [1:0]                           out_direction_code,
  output logic                                 out_moving
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSTART,
    ST_PASS,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                        state_r;
  stp_pkg::stp_mode_t            mode_r;
  stp_pkg::stp_mode_t            in_mode_e;
  logic [stp_pkg::SPEED_W-1:0]   default_speed_r;
  logic                          eal_r;
  logic [stp_pkg::SPEED_W-1:0]   spd_r;
  logic [1:0]                    direction_r;
  logic                          moving_r;
  logic [stp_pkg::SPEED_W-1:0]   interval_r;
  logic                          first_r;
  logic                          enabled_r;
  logic                          dir_pin_r;
  logic                          pulse_r;
  logic                          out_valid_r;

  logic                          accept;
  logic                          fire;
  logic [stp_pkg::SPEED_W-1:0]   divisor;
  logic                          div_valid;
  logic [stp_pkg::SPEED_W-1:0]   div_q;
  stp_pkg::stp_ctl_t             ctl;
  stp_pkg::stp_flags_t           flags;
  logic [stp_pkg::POS_W-1:0]     position;
  logic [stp_pkg::POS_W-1:0]     target;

  assign in_mode_e = stp_pkg::stp_mode_t'(in_mode);
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;

  // speed zero picks the default; a zero default counts as one
  always_comb begin
    if (spd_r != '0)
      divisor = spd_r;
    else if (default_speed_r != '0)
      divisor = default_speed_r;
    else
      divisor = stp_pkg::SPEED_W'(1);
  end

  // while moving, a tick fires on the first tick after a move or once the interval is up
  assign fire = moving_r && (first_r || flags.ge);

  always_comb begin
    ctl.start    = (accept && in_mode_e == stp_pkg::MODE_TICK) || (state_r == ST_MSTART);
    ctl.kind     = (state_r == ST_MSTART) ? stp_pkg::PASS_MOVE : stp_pkg::PASS_TICK;
    ctl.load_tgt = accept && (in_mode_e == stp_pkg::MODE_MOVE ||
                              in_mode_e == stp_pkg::MODE_SETPOS);
    ctl.load_pos = accept && (in_mode_e == stp_pkg::MODE_SETPOS);
    ctl.commit   = (state_r == ST_PASS) && (mode_r == stp_pkg::MODE_TICK) &&
                   flags.last && fire && !flags.eq_old;
    ctl.dir_neg  = (direction_r == stp_pkg::DIR_NEG);
  end

  stp_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .load_val (in_target_steps),
    .now_val  (in_now_micros),
    .ivl_val  (interval_r),
    .flags    (flags),
    .position (position),
    .target   (target)
  );

  stp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_MSTART),
    .divisor  (divisor),
    .valid    (div_valid),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      mode_r          <= stp_pkg::MODE_MOVE;
      default_speed_r <= stp_pkg::DEFAULT_SPEED_RST;
      eal_r           <= 1'b1;
      direction_r     <= stp_pkg::DIR_NONE;
      moving_r        <= 1'b0;
      interval_r      <= '0;
      first_r         <= 1'b1;
      enabled_r       <= 1'b0;
      dir_pin_r       <= 1'b0;
      pulse_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          stp_pkg::CFG_DEFAULT_SPEED:     default_speed_r <= cfg_wdata;
          stp_pkg::CFG_ENABLE_ACTIVE_LOW: eal_r           <= cfg_wdata[0];
          default: ;
        endcase
      end

      // in the final state a taken result is replaced by the next one
      if (out_valid_r && out_ready && state_r != ST_FIN) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode_e;
            pulse_r <= 1'b0;
            case (in_mode_e)
              stp_pkg::MODE_MOVE: begin
                spd_r   <= in_speed_steps_per_sec;
                state_r <= ST_MSTART;
              end
              stp_pkg::MODE_TICK: state_r <= ST_PASS;
              stp_pkg::MODE_STOP: begin
                moving_r    <= 1'b0;
                direction_r <= stp_pkg::DIR_NONE;
                enabled_r   <= 1'b0;
                state_r     <= ST_FIN;
              end
              default: state_r <= ST_FIN;
            endcase
          end
        end

        ST_MSTART: state_r <= ST_PASS;

        ST_PASS: begin
          if (flags.last) begin
            if (mode_r == stp_pkg::MODE_MOVE) begin
              if (flags.eq_old) begin
                // move to where the axis already is: halt and disable
                moving_r    <= 1'b0;
                direction_r <= stp_pkg::DIR_NONE;
                enabled_r   <= 1'b0;
                state_r     <= ST_FIN;
              end else begin
                direction_r <= flags.tgt_gt ? stp_pkg::DIR_POS : stp_pkg::DIR_NEG;
                dir_pin_r   <= flags.tgt_gt;
                first_r     <= 1'b1;
                moving_r    <= 1'b1;
                enabled_r   <= 1'b1;
                state_r     <= ST_DIV;
              end
            end else begin
              if (fire) begin
                if (flags.eq_old || flags.eq_new) begin
                  moving_r    <= 1'b0;
                  direction_r <= stp_pkg::DIR_NONE;
                  enabled_r   <= 1'b0;
                end
                if (!flags.eq_old) begin
                  pulse_r <= 1'b1;
                  first_r <= 1'b0;
                end
              end
              state_r <= ST_FIN;
            end
          end
        end

        ST_DIV: begin
          if (div_valid) begin
            interval_r <= div_q;
            state_r    <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_step_pulse      <= pulse_r;
            out_dir_level       <= dir_pin_r;
            out_enable_level    <= enabled_r ^ eal_r;
            out_position_steps  <= position;
            out_target_position <= target;
            out_direction_code  <= direction_r;
            out_moving          <= moving_r;
            out_valid_r         <= 1'b1;
            state_r             <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sim/stepper_step_dir_generator_core_test.sv
// Self-checking bench for the stepper step/direction generator core.
module stepper_step_dir_generator_core_test;
  import stp_pkg::*;

  localparam int RUN_LIMIT   = 500000;  // cycles
  localparam int HOLD_CYCLES = 600;     // long receiver hold-off, fills the block
  localparam int TAIL_CYCLES = 40;      // longer than one move plus output register

  // one result item as the block shows it
  typedef struct packed {
    logic             step_pulse;
    logic             dir_level;
    logic             enable_level;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] target;
    logic [1:0]       direction;
    logic             moving;
  } axis_view_t;

  // Tracks the axis as the block should, and holds the result items still owed.
  class axis_tracker;
    logic [SPEED_W-1:0] default_speed;
    logic               en_active_low;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   target;
    logic [POS_W-1:0]   last_step_us;
    logic [1:0]         direction;
    logic               moving;
    logic               first_pending;
    logic               enabled;
    logic               dir_pin;
    logic [SPEED_W-1:0] interval;
    axis_view_t         owed_views[$];
    int                 mismatches;

    function new();
      clear();
    endfunction

    function void clear();
      default_speed = DEFAULT_SPEED_RST;
      en_active_low = 1'b1;
      position      = '0;
      target        = '0;
      last_step_us  = '0;
      direction     = DIR_NONE;
      moving        = 1'b0;
      first_pending = 1'b1;
      enabled       = 1'b0;
      dir_pin       = 1'b0;
      interval      = '0;
      mismatches    = 0;
      owed_views.delete();
    endfunction

    function void halt();
      moving    = 1'b0;
      direction = DIR_NONE;
      enabled   = 1'b0;
    endfunction

    function string show(axis_view_t v);
      return $sformatf("pulse %0b dir %0b en %0b pos %h tgt %h code %0d moving %0b",
                       v.step_pulse, v.dir_level, v.enable_level, v.position,
                       v.target, v.direction, v.moving);
    endfunction

    // accepted input item: advance the axis and owe one result item
    function void take_command(stp_mode_t mode, logic [POS_W-1:0] tgt,
                               logic [SPEED_W-1:0] spd, logic [POS_W-1:0] now);
      logic [POS_W-1:0] rate;
      logic [POS_W-1:0] quotient;
      axis_view_t       v;
      v.step_pulse = 1'b0;
      case (mode)
        MODE_MOVE: begin
          target = tgt;
          if (target == position) begin
            halt();
          end else begin
            rate = (spd != '0) ? {12'd0, spd} : {12'd0, default_speed};
            if (rate == '0) rate = 32'd1;   // zero default speed counts as one
            direction     = ($signed(target) > $signed(position)) ? DIR_POS : DIR_NEG;
            quotient      = {12'd0, MICROS_PER_SEC} / rate;
            interval      = quotient[SPEED_W-1:0];
            first_pending = 1'b1;
            moving        = 1'b1;
            dir_pin       = (direction == DIR_POS);
            enabled       = 1'b1;
          end
        end
        MODE_TICK: begin
          if (moving && (first_pending || (now - last_step_us) >= {12'd0, interval})) begin
            if (position == target) begin
              halt();
            end else begin
              v.step_pulse  = 1'b1;
              position      = (direction == DIR_POS) ? position + 32'd1 : position - 32'd1;
              last_step_us  = now;
              first_pending = 1'b0;
              if (position == target) halt();
            end
          end
        end
        MODE_STOP: begin
          halt();
        end
        default: begin
          position = tgt;
          target   = tgt;
        end
      endcase
      v.dir_level    = dir_pin;
      v.enable_level = enabled ^ en_active_low;
      v.position     = position;
      v.target       = target;
      v.direction    = direction;
      v.moving       = moving;
      owed_views.push_back(v);
    endfunction

    // accepted result item: compare with the oldest one owed
    function void match_result(axis_view_t got);
      axis_view_t want;
      if (owed_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with none owed: %s", show(got));
        return;
      end
      want = owed_views.pop_front();
      if (got.step_pulse !== want.step_pulse || got.dir_level !== want.dir_level ||
          got.enable_level !== want.enable_level || got.position !== want.position ||
          got.target !== want.target || got.direction !== want.direction ||
          got.moving !== want.moving) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [SPEED_W-1:0]        cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_mode = '0;
  logic signed [POS_W-1:0]   in_target_steps = '0;
  logic [SPEED_W-1:0]        in_speed_steps_per_sec = '0;
  logic [POS_W-1:0]          in_now_micros = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_step_pulse;
  logic                      out_dir_level;
  logic                      out_enable_level;
  logic signed [POS_W-1:0]   out_position_steps;
  logic signed [POS_W-1:0]   out_target_position;
  logic [1:0]                out_direction_code;
  logic                      out_moving;

  axis_tracker tracker = new();

  // sender pacing
  int          items_sent = 0;
  int          burst_left = 0;
  int          gap_max = 3;
  logic [31:0] now_us = '0;     // the bench's microsecond clock for ticks

  // receiver pacing: style 0 always ready, 1 random, 2 run-length pattern
  int          rx_style = 1;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_run = 0;
  logic        rx_open = 1'b1;
  int          cycles = 0;

  stepper_step_dir_generator_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_mode                (in_mode),
    .in_target_steps        (in_target_steps),
    .in_speed_steps_per_sec (in_speed_steps_per_sec),
    .in_now_micros          (in_now_micros),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_step_pulse         (out_step_pulse),
    .out_dir_level          (out_dir_level),
    .out_enable_level       (out_enable_level),
    .out_position_steps     (out_position_steps),
    .out_target_position    (out_target_position),
    .out_direction_code     (out_direction_code),
    .out_moving             (out_moving)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d result items still owed",
               cycles, tracker.owed_views.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check every accepted result item, then decide ready for the
  // next edge. A hold-off request from the stimulus side is counted down here.
  always @(posedge clk) begin : result_side
    axis_view_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.step_pulse   = out_step_pulse;
      seen.dir_level    = out_dir_level;
      seen.enable_level = out_enable_level;
      seen.position     = out_position_steps;
      seen.target       = out_target_position;
      seen.direction    = out_direction_code;
      seen.moving       = out_moving;
      tracker.match_result(seen);
    end
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          // alternate runs of ready and stall of random length
          if (stall_run == 0) begin
            rx_open   = !rx_open;
            stall_run = rx_open ? $urandom_range(1, 9) : $urandom_range(1, 5);
          end else begin
            stall_run--;
          end
          out_ready <= rx_open;
        end
      endcase
    end
  end

  // Offer one item, hold it until taken, then maybe leave a gap. Valid stays
  // high between items of a burst.
  task automatic send_item(input stp_mode_t mode, input logic [POS_W-1:0] tgt,
                           input logic [SPEED_W-1:0] spd, input logic [POS_W-1:0] now);
    int gap;
    in_valid               <= 1'b1;
    in_mode                <= mode;
    in_target_steps        <= tgt;
    in_speed_steps_per_sec <= spd;
    in_now_micros          <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_command(mode, tgt, spd, now);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // wait until every owed result item has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.owed_views.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEFAULT_SPEED) tracker.default_speed = val;
    else tracker.en_active_low = val[0];
  endtask

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(0, 7))
      0:       return '0;                          // falls back to the default
      1:       return 20'd1;
      2:       return MICROS_PER_SEC;
      3:       return 20'($urandom_range(1_000_001, 20'hFFFFF));  // interval 0
      4:       return 20'($urandom_range(1, 50));
      default: return 20'($urandom_range(1, 1_000_000));
    endcase
  endfunction

  // tick time, mostly close to the current step interval
  function automatic logic [POS_W-1:0] pick_now();
    logic [POS_W-1:0] step_us;
    step_us = {12'd0, tracker.interval};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: now_us = now_us + step_us + $urandom_range(0, 2) - 1;
      4, 5:       now_us = now_us + $urandom_range(0, step_us);
      6:          now_us = now_us + $urandom_range(0, 3);
      7:          now_us = now_us + $urandom;
      8:          now_us = $urandom;                 // time jumps backwards too
      default:    now_us = 32'hFFFF_FFFF - $urandom_range(0, 5);  // just before wrap
    endcase
    return now_us;
  endfunction

  task automatic directed_items();
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd0);                   // tick while idle
    send_item(MODE_MOVE, 32'd0, 20'd5, 32'd0);                   // move onto own position
    send_item(MODE_MOVE, 32'd3, 20'd0, 32'd0);                   // default speed
    send_item(MODE_TICK, 32'd0, 20'd0, 32'hFFFF_FF00);           // first step at once
    send_item(MODE_TICK, 32'd0, 20'd0, 32'h0000_02E7);           // 999 us, across wrap
    send_item(MODE_TICK, 32'd0, 20'd0, 32'h0000_02E8);           // 1000 us: step
    send_item(MODE_STOP, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    send_item(MODE_TICK, 32'd0, 20'd0, 32'h0010_0000);
    send_item(MODE_SETPOS, 32'h7FFF_FFFF, 20'd0, 32'd0);
    send_item(MODE_MOVE, 32'h8000_0000, 20'hFFFFF, 32'd0);       // above 1e6: interval 0
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd0);
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd0);
    send_item(MODE_SETPOS, 32'h8000_0000, 20'd0, 32'd0);         // set position mid-move
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd1);                   // stops, no step
    send_item(MODE_MOVE, 32'h8000_0002, 20'd1, 32'd0);           // slowest speed
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd5);
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd1_000_004);
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd1_000_005);           // last step, halts
    send_item(MODE_MOVE, 32'h8000_0001, MICROS_PER_SEC, 32'd0);
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd7);
    send_item(MODE_TICK, 32'd0, 20'd0, 32'd8);
    send_item(MODE_MOVE, 32'h8000_0003, 20'd1_000_001, 32'd0);
    send_item(MODE_SETPOS, 32'd0, 20'hFFFFF, 32'hFFFF_FFFF);
    send_item(MODE_MOVE, 32'd0, 20'd7, 32'd0);                   // target already reached
    send_item(MODE_TICK, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);
  endtask

  // Mostly a move followed by a run of ticks; the rest stops, position loads
  // and fully random items.
  task automatic random_items(input int goal);
    int               stop_at;
    int               off;
    logic [POS_W-1:0] tgt;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          off = $urandom_range(1, 6);
          case ($urandom_range(0, 9))
            0:       tgt = tracker.position;
            1:       tgt = $urandom;
            default: tgt = ($urandom_range(0, 1) != 0) ? tracker.position + off
                                                       : tracker.position - off;
          endcase
          send_item(MODE_MOVE, tgt, pick_speed(), $urandom);
          repeat ($urandom_range(2, 14))
            send_item(MODE_TICK, $urandom, 20'($urandom), pick_now());
        end
        7: send_item(MODE_STOP, $urandom, 20'($urandom), $urandom);
        8: begin
          case ($urandom_range(0, 3))
            0:       tgt = 32'h7FFF_FFFF;
            1:       tgt = 32'h8000_0000;
            2:       tgt = $urandom;
            default: tgt = tracker.position + $urandom_range(0, 3);
          endcase
          send_item(MODE_SETPOS, tgt, 20'($urandom), $urandom);
        end
        default: send_item(stp_mode_t'($urandom_range(0, 3)), $urandom, 20'($urandom),
                           $urandom);
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    tracker.clear();
    directed_items();

    // Six phases; registers change only once the block has gone quiet.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_reg(CFG_ENABLE_ACTIVE_LOW, {19'($urandom), 1'b0});
        1: write_reg(CFG_DEFAULT_SPEED, 20'd0);
        2: begin
          write_reg(CFG_DEFAULT_SPEED, 20'hFFFFF);
          write_reg(CFG_ENABLE_ACTIVE_LOW, {19'($urandom), 1'b1});
        end
        3: write_reg(CFG_DEFAULT_SPEED, 20'd1);
        4: begin
          write_reg(CFG_DEFAULT_SPEED, 20'($urandom_range(2, 999_999)));
          write_reg(CFG_ENABLE_ACTIVE_LOW, {19'($urandom), 1'b0});
        end
        default: begin
          write_reg(CFG_DEFAULT_SPEED, MICROS_PER_SEC);
          write_reg(CFG_ENABLE_ACTIVE_LOW, {19'($urandom), 1'b1});
        end
      endcase
      // phases 0 and 3 run flat out on the input side
      case (ph)
        0:       begin gap_max = 0; rx_style = 0; end
        1:       begin gap_max = 4; rx_style = 1; end
        2:       begin gap_max = 8; rx_style = 2; end
        3:       begin gap_max = 0; rx_style = 2; end
        4:       begin gap_max = 3; rx_style = 0; end
        default: begin gap_max = 6; rx_style = 1; end
      endcase
      if (ph == 2 || ph == 4) hold_req = 1'b1;
      random_items(220);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d result items still owed",
               tracker.mismatches, tracker.owed_views.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
